>>> hw/rtl/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Types and fixed widths shared by the box pair metrics block.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int CoordW  = 15;
  localparam int ExtW    = 15;
  localparam int VolW    = 60;
  localparam int MarginW = 17;
  localparam int CntW    = 3;

  // one dimension of a box pair, as it arrives on the input channel
  typedef struct packed {
    logic [CoordW-1:0] a_lo;
    logic [CoordW-1:0] a_hi;
    logic [CoordW-1:0] b_lo;
    logic [CoordW-1:0] b_hi;
    logic              last_dim;
  } in_beat_t;

  // one result, on the output channel
  typedef struct packed {
    logic [VolW-1:0]      area_a;
    logic [VolW-1:0]      area_b;
    logic [VolW:0]        area_sum;
    logic [MarginW-1:0]   margin_a;
    logic [MarginW-1:0]   margin_b;
    logic [MarginW:0]     margin_sum;
    logic [VolW-1:0]      overlap_volume;
    logic                 boxes_touch;
    logic                 bad_box;
  } out_beat_t;

  // per-dimension terms, worked out before the input register
  typedef struct packed {
    logic            last;
    logic            inv;
    logic            disj;
    logic            apart;
    logic [ExtW-1:0] ea;
    logic [ExtW-1:0] eb;
    logic [ExtW-1:0] eo;
  } dim_t;

  // result register contents; the pair sums are added on the way out
  typedef struct packed {
    logic [VolW-1:0]    area_a;
    logic [VolW-1:0]    area_b;
    logic [MarginW-1:0] margin_a;
    logic [MarginW-1:0] margin_b;
    logic [VolW-1:0]    overlap;
    logic               touch;
    logic               bad;
  } res_t;

endpackage

>>> hw/rtl/bpm_dim_prep.sv
// ----------------------------------------------------------------------------
// bpm_dim_prep
// Masks one dimension's coordinates and derives extents and pair tests.
// ----------------------------------------------------------------------------
module bpm_dim_prep #(
  parameter int COORD_BITS = 15
) (
  input  bpm_pkg::in_beat_t beat,
  output bpm_pkg::dim_t     dim
);

  localparam logic [bpm_pkg::CoordW-1:0] CoordMask =
    bpm_pkg::CoordW'((64'd1 << COORD_BITS) - 64'd1);

  logic [bpm_pkg::CoordW-1:0] alo, ahi, blo, bhi, hmin, lmax;

  always_comb begin
    alo  = beat.a_lo & CoordMask;
    ahi  = beat.a_hi & CoordMask;
    blo  = beat.b_lo & CoordMask;
    bhi  = beat.b_hi & CoordMask;
    hmin = (ahi < bhi) ? ahi : bhi;
    lmax = (alo > blo) ? alo : blo;

    dim.last  = beat.last_dim;
    dim.inv   = (alo >= ahi) || (blo >= bhi);
    dim.disj  = (alo >= bhi) || (blo >= ahi);
    dim.apart = (alo > bhi) || (blo > ahi);
    // an empty extent counts as zero
    dim.ea    = (ahi > alo) ? bpm_pkg::ExtW'(ahi - alo) : '0;
    dim.eb    = (bhi > blo) ? bpm_pkg::ExtW'(bhi - blo) : '0;
    dim.eo    = (hmin > lmax) ? bpm_pkg::ExtW'(hmin - lmax) : '0;
  end

endmodule

>>> hw/rtl/bpm_accum.sv
// ----------------------------------------------------------------------------
// bpm_accum
// Per-pair accumulators and the result register.
// ----------------------------------------------------------------------------
module bpm_accum #(
  parameter int DIMS = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          dim_valid,
  input  bpm_pkg::dim_t dim,
  output logic          dim_take,
  output logic          res_valid,
  input  logic          res_ready,
  output bpm_pkg::res_t res
);

  localparam int ProdW = bpm_pkg::VolW + bpm_pkg::ExtW;

  logic [bpm_pkg::VolW-1:0]    vol_a_r, vol_a_nxt, vol_b_r, vol_b_nxt;
  logic [bpm_pkg::VolW-1:0]    ovl_r, ovl_nxt;
  logic [bpm_pkg::MarginW-1:0] mar_a_r, mar_a_nxt, mar_b_r, mar_b_nxt;
  logic                        disj_r, disj_nxt, apart_r, apart_nxt, inv_r, inv_nxt;
  logic [bpm_pkg::CntW-1:0]    dim_cnt_r, dim_cnt_nxt;
  logic                        res_valid_r, res_valid_nxt;
  bpm_pkg::res_t               res_r, res_nxt;
  logic [ProdW-1:0]            prod_a, prod_b, prod_o;
  logic                        dim_ok, res_load;

  // only a closing beat can be held up, and only by a full result register
  assign dim_take = dim_valid && (!dim.last || !res_valid_r || res_ready);
  assign res_load = dim_take && dim.last;
  assign dim_ok   = dim_cnt_r < bpm_pkg::CntW'(DIMS);

  assign prod_a = ProdW'(vol_a_r) * ProdW'(dim.ea);
  assign prod_b = ProdW'(vol_b_r) * ProdW'(dim.eb);
  assign prod_o = ProdW'(ovl_r) * ProdW'(dim.eo);

  always_comb begin
    vol_a_nxt   = vol_a_r;
    vol_b_nxt   = vol_b_r;
    ovl_nxt     = ovl_r;
    mar_a_nxt   = mar_a_r;
    mar_b_nxt   = mar_b_r;
    disj_nxt    = disj_r;
    apart_nxt   = apart_r;
    inv_nxt     = inv_r;
    dim_cnt_nxt = dim_cnt_r;
    res_nxt     = res_r;

    if (dim_take) begin
      inv_nxt = inv_r || dim.inv || !dim_ok;
      // dimensions past the limit only raise the bad flag
      if (dim_ok) begin
        vol_a_nxt = prod_a[bpm_pkg::VolW-1:0];
        vol_b_nxt = prod_b[bpm_pkg::VolW-1:0];
        mar_a_nxt = mar_a_r + bpm_pkg::MarginW'(dim.ea);
        mar_b_nxt = mar_b_r + bpm_pkg::MarginW'(dim.eb);
        disj_nxt  = disj_r || dim.disj;
        apart_nxt = apart_r || dim.apart;
        if (!dim.disj) begin
          ovl_nxt = prod_o[bpm_pkg::VolW-1:0];
        end
      end
      if (dim_cnt_r != '1) begin
        dim_cnt_nxt = dim_cnt_r + 1'b1;
      end
    end

    if (res_load) begin
      res_nxt.area_a   = vol_a_nxt;
      res_nxt.area_b   = vol_b_nxt;
      res_nxt.margin_a = mar_a_nxt;
      res_nxt.margin_b = mar_b_nxt;
      res_nxt.overlap  = disj_nxt ? '0 : ovl_nxt;
      res_nxt.touch    = !apart_nxt;
      res_nxt.bad      = inv_nxt;
      vol_a_nxt   = bpm_pkg::VolW'(1);
      vol_b_nxt   = bpm_pkg::VolW'(1);
      ovl_nxt     = bpm_pkg::VolW'(1);
      mar_a_nxt   = '0;
      mar_b_nxt   = '0;
      disj_nxt    = 1'b0;
      apart_nxt   = 1'b0;
      inv_nxt     = 1'b0;
      dim_cnt_nxt = '0;
    end

    if (res_load) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_a_r     <= bpm_pkg::VolW'(1);
      vol_b_r     <= bpm_pkg::VolW'(1);
      ovl_r       <= bpm_pkg::VolW'(1);
      mar_a_r     <= '0;
      mar_b_r     <= '0;
      disj_r      <= 1'b0;
      apart_r     <= 1'b0;
      inv_r       <= 1'b0;
      dim_cnt_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      vol_a_r     <= vol_a_nxt;
      vol_b_r     <= vol_b_nxt;
      ovl_r       <= ovl_nxt;
      mar_a_r     <= mar_a_nxt;
      mar_b_r     <= mar_b_nxt;
      disj_r      <= disj_nxt;
      apart_r     <= apart_nxt;
      inv_r       <= inv_nxt;
      dim_cnt_r   <= dim_cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // a closing beat leaves the accumulators cleared
  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (dim_cnt_r == '0) && (vol_a_r == bpm_pkg::VolW'(1)) && !inv_r)
    else $error("accumulators not cleared after closing beat");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_ready |-> !res_load)
    else $error("result register overwritten while held");

  // boxes apart in some dimension cannot share volume
  a_apart_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_r.touch |-> res_r.overlap == '0)
    else $error("overlap reported for boxes that do not touch");

  // a good pair has non-empty boxes
  a_good_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_r.bad |-> (res_r.area_a != '0) && (res_r.area_b != '0))
    else $error("zero area on a pair not flagged bad");

endmodule

>>> hw/rtl/box_pair_metrics.sv
// ----------------------------------------------------------------------------
// box_pair_metrics
// Volume, margin, overlap and touch metrics of two axis-aligned boxes.
// ----------------------------------------------------------------------------
// One dimension of a box pair is taken per beat, one beat every cycle; the
// beat with last_dim set passes the input register and then the result
// register, from which its result is presented on the output. The figure
// of one beat per cycle is set by the three 60x15 multiply-accumulate loops
// (area of each box and overlap). Input is held back only when a closing
// beat meets a result that has not yet been taken. Extents of empty boxes
// count as zero; bad_box flags such boxes and pairs with more than DIMS
// dimensions.
module box_pair_metrics #(
  parameter int DIMS       = 3,
  parameter int COORD_BITS = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpm_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bpm_pkg::out_beat_t  out_data
);

  bpm_pkg::dim_t dim_in, dim_r;
  logic          dim_valid_r, dim_valid_nxt, dim_take, in_fire;
  bpm_pkg::res_t res;

  bpm_dim_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .beat (in_data),
    .dim  (dim_in)
  );

  assign in_ready = !dim_valid_r || dim_take;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (in_fire) begin
      dim_valid_nxt = 1'b1;
    end else if (dim_take) begin
      dim_valid_nxt = 1'b0;
    end else begin
      dim_valid_nxt = dim_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_valid_r <= 1'b0;
    end else begin
      dim_valid_r <= dim_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dim_r <= dim_in;
    end
  end

  bpm_accum #(.DIMS(DIMS)) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .dim_valid (dim_valid_r),
    .dim       (dim_r),
    .dim_take  (dim_take),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  always_comb begin
    out_data.area_a         = res.area_a;
    out_data.area_b         = res.area_b;
    out_data.area_sum       = {1'b0, res.area_a} + {1'b0, res.area_b};
    out_data.margin_a       = res.margin_a;
    out_data.margin_b       = res.margin_b;
    out_data.margin_sum     = {1'b0, res.margin_a} + {1'b0, res.margin_b};
    out_data.overlap_volume = res.overlap;
    out_data.boxes_touch    = res.touch;
    out_data.bad_box        = res.bad;
  end

endmodule

>>> tb/sv/box_pair_metrics_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_pair_metrics_checker
// Watches both channels of box_pair_metrics, folds each accepted dimension
// beat into its own copy of the pair accumulators and checks every result
// beat, field by field, against the oldest predicted metrics.
// ----------------------------------------------------------------------------
module box_pair_metrics_checker #(
  parameter int DIMS       = 3,
  parameter int COORD_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  bpm_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  bpm_pkg::out_beat_t out_data,
  output int                 fail_count,
  output int                 metrics_waiting
);

  localparam logic [bpm_pkg::CoordW-1:0] CoordMask =
    bpm_pkg::CoordW'((1 << COORD_BITS) - 1);
  localparam logic [2:0] DimSat = 3'd7;

  // running state of the pair being received
  logic [bpm_pkg::VolW-1:0]    vol_a;
  logic [bpm_pkg::VolW-1:0]    vol_b;
  logic [bpm_pkg::VolW-1:0]    overlap_prod;
  logic [bpm_pkg::MarginW-1:0] margin_a;
  logic [bpm_pkg::MarginW-1:0] margin_b;
  logic                        strictly_apart;
  logic                        closed_apart;
  logic                        bad_seen;
  logic [2:0]                  dims_taken;

  bpm_pkg::out_beat_t expected_metrics[$];
  int                 errors = 0;
  int                 waiting = 0;

  assign fail_count      = errors;
  assign metrics_waiting = waiting;

  task automatic clear_pair();
    vol_a          = bpm_pkg::VolW'(1);
    vol_b          = bpm_pkg::VolW'(1);
    overlap_prod   = bpm_pkg::VolW'(1);
    margin_a       = '0;
    margin_b       = '0;
    strictly_apart = 1'b0;
    closed_apart   = 1'b0;
    bad_seen       = 1'b0;
    dims_taken     = '0;
  endtask

  task automatic fold_dimension(input bpm_pkg::in_beat_t b);
    logic [bpm_pkg::CoordW-1:0] alo, ahi, blo, bhi, ea, eb, hmin, lmax;
    bpm_pkg::out_beat_t         r;
    alo = b.a_lo & CoordMask;
    ahi = b.a_hi & CoordMask;
    blo = b.b_lo & CoordMask;
    bhi = b.b_hi & CoordMask;
    if (alo >= ahi || blo >= bhi) bad_seen = 1'b1;
    if (dims_taken >= DIMS) begin
      // surplus dimension: flagged, otherwise ignored
      bad_seen = 1'b1;
    end else begin
      ea = (ahi > alo) ? ahi - alo : '0;
      eb = (bhi > blo) ? bhi - blo : '0;
      vol_a    = vol_a * ea;
      vol_b    = vol_b * eb;
      margin_a = margin_a + ea;
      margin_b = margin_b + eb;
      if (alo >= bhi || blo >= ahi) begin
        strictly_apart = 1'b1;
      end else begin
        hmin = (ahi < bhi) ? ahi : bhi;
        lmax = (alo > blo) ? alo : blo;
        overlap_prod = overlap_prod * ((hmin > lmax) ? hmin - lmax : '0);
      end
      if (alo > bhi || blo > ahi) closed_apart = 1'b1;
    end
    if (dims_taken < DimSat) dims_taken = dims_taken + 3'd1;
    if (b.last_dim) begin
      r.area_a         = vol_a;
      r.area_b         = vol_b;
      r.area_sum       = vol_a + vol_b;
      r.margin_a       = margin_a;
      r.margin_b       = margin_b;
      r.margin_sum     = margin_a + margin_b;
      r.overlap_volume = strictly_apart ? '0 : overlap_prod;
      r.boxes_touch    = !closed_apart;
      r.bad_box        = bad_seen;
      expected_metrics = {expected_metrics, r};
      clear_pair();
    end
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    bpm_pkg::out_beat_t e;
    if (!rst_n) begin
      clear_pair();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_metrics.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, out_data);
          errors++;
        end else begin
          e = expected_metrics.pop_front();
          check_field("area_a",         e.area_a,         out_data.area_a);
          check_field("area_b",         e.area_b,         out_data.area_b);
          check_field("area_sum",       e.area_sum,       out_data.area_sum);
          check_field("margin_a",       e.margin_a,       out_data.margin_a);
          check_field("margin_b",       e.margin_b,       out_data.margin_b);
          check_field("margin_sum",     e.margin_sum,     out_data.margin_sum);
          check_field("overlap_volume", e.overlap_volume, out_data.overlap_volume);
          check_field("boxes_touch",    e.boxes_touch,    out_data.boxes_touch);
          check_field("bad_box",        e.bad_box,        out_data.bad_box);
        end
      end
      if (in_valid && in_ready) fold_dimension(in_data);
    end
    waiting = expected_metrics.size();
  end

endmodule

>>> tb/sv/tb_box_pair_metrics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_pair_metrics
// Streams box pairs into box_pair_metrics, directed corner pairs first and
// then random pairs under several idling and back-pressure mixes; the
// checker alongside predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_box_pair_metrics;

  localparam int DIMS         = 3;
  localparam int COORD_BITS   = 15;
  localparam int RandomBeats  = 850;
  localparam int CoordMax     = (1 << bpm_pkg::CoordW) - 1;
  localparam int DrainCycles  = 20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  bpm_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bpm_pkg::out_beat_t out_data;
  int                 fail_count;
  int                 metrics_waiting;

  int idle_pct  = 0;
  int stall_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  box_pair_metrics #(.DIMS(DIMS), .COORD_BITS(COORD_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  box_pair_metrics_checker #(.DIMS(DIMS), .COORD_BITS(COORD_BITS)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .metrics_waiting(metrics_waiting)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // valid is only dropped when a gap is taken, so it never toggles in one step
  task automatic send_dim(input int alo, input int ahi, input int blo, input int bhi,
                          input bit last);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{a_lo: bpm_pkg::CoordW'(alo), a_hi: bpm_pkg::CoordW'(ahi),
                  b_lo: bpm_pkg::CoordW'(blo), b_hi: bpm_pkg::CoordW'(bhi),
                  last_dim: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // one box edge pair inside a window; mostly well-formed, now and then inverted
  task automatic draw_extent(input int base, input int span, output int lo, output int hi);
    int c0, c1;
    c0 = base + $urandom_range(span);
    c1 = base + $urandom_range(span);
    if ($urandom_range(19) == 0 || c0 <= c1) begin
      lo = c0;
      hi = c1;
    end else begin
      lo = c1;
      hi = c0;
    end
  endtask

  initial begin
    int sent, ndims, span, base, alo, ahi, blo, bhi;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_dim(0, CoordMax, 0, CoordMax, 1'b1);
    for (int d = 0; d < DIMS; d++) send_dim(0, CoordMax, 0, CoordMax, d == DIMS - 1);
    send_dim(100, 100, 0, 200, 1'b1);          // empty first box
    send_dim(0, 50, CoordMax, 0, 1'b1);        // inverted second box
    send_dim(0, 10, 20, 30, 1'b1);             // apart, no touch
    send_dim(0, 10, 10, 20, 1'b1);             // faces meet: touch, zero overlap
    send_dim(50, 40, 0, 100, 1'b1);            // strict test passes on an empty box
    for (int d = 0; d < DIMS + 2; d++) send_dim(d, 3 * d + 7, d + 1, 5 * d + 9, d == DIMS + 1);
    for (int d = 0; d < 9; d++) send_dim(2 * d, 2 * d + 9, d, d + 4, d == 8);

    // random pairs, four idling mixes in turn
    sent = 0;
    while (sent < RandomBeats) begin
      case (sent * 4 / RandomBeats)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 82; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 6;  stall_pct = 6;  end
      endcase
      ndims = ($urandom_range(9) == 0) ? $urandom_range(9, DIMS + 1) : $urandom_range(DIMS, 1);
      case ($urandom_range(3))
        0:       span = CoordMax;
        1:       span = 1023;
        2:       span = 15;
        default: span = 3;
      endcase
      for (int d = 0; d < ndims; d++) begin
        base = $urandom_range(CoordMax - span);
        draw_extent(base, span, alo, ahi);
        draw_extent(base, span, blo, bhi);
        send_dim(alo, ahi, blo, bhi, d == ndims - 1);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (metrics_waiting != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
